/* hdl/sbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbp_pkg: shared types and constants of the splitter bucket partitioner
// Sizes of the splitter and bucket tables, operation codes, the request and
// result beats, and the command and status groups between control and datapath.
// ----------------------------------------------------------------------------
package sbp_pkg;

    localparam int BUCKETS = 64;
    localparam int NSPLIT  = BUCKETS - 1;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int SPAN    = 2 ** BKT_W;
    localparam int LOC_W   = BKT_W + 1;
    localparam int CNT_W   = BKT_W + 1;

    localparam logic [2:0] OP_SET_SPLITTER = 3'd0;
    localparam logic [2:0] OP_SET_BASE     = 3'd1;
    localparam logic [2:0] OP_CLASSIFY     = 3'd2;
    localparam logic [2:0] OP_READ         = 3'd3;
    localparam logic [2:0] OP_PREFIX       = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [5:0]  slot;
        logic [63:0] sort_key;
        logic [63:0] record_tag;
        logic [31:0] offset_value;
    } request_t;

    typedef struct packed {
        logic [5:0]  bucket;
        logic [31:0] position;
        logic [63:0] out_key;
        logic [63:0] out_tag;
        logic [31:0] read_value;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the request beat, issue first reads, do set writes
        logic probe;    // one step of the splitter search
        logic update;   // classify read-modify-write of the fill count
        logic sweep;    // one bucket of the prefix pass
        logic finish;   // plain result for set, read and unused operations
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic search_last;  // current probe is the final one
        logic sweep_last;   // prefix pass handles its last bucket
    } dp_stat_t;

endpackage

/* hdl/sbp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbp_ctrl: operation sequencer
// Accepts a request beat, then steps the datapath through search, fill update,
// prefix sweep or a single result state.
// ----------------------------------------------------------------------------
module sbp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0]       operation,
    input  sbp_pkg::dp_stat_t stat,
    output logic             busy,
    output sbp_pkg::dp_cmd_t cmd
);
    import sbp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_SWEEP  = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (operation == OP_CLASSIFY)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else if (operation == OP_PREFIX)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.probe = 1'b1;
                if (stat.search_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not leave idle");

    a_update_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> ($past(state_reg) == ST_SEARCH) && $past(stat.search_last))
        else $error("fill update without a finished search");

endmodule

/* hdl/sbp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbp_datapath: splitter, base and fill tables with search and prefix logic
// Holds the three tables with per-entry valid bits, the binary search probe,
// the fill read-modify-write, the prefix running total and the result register.
// ----------------------------------------------------------------------------
module sbp_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  sbp_pkg::request_t  request,
    input  sbp_pkg::dp_cmd_t   cmd,
    output sbp_pkg::dp_stat_t  stat,
    output logic               done,
    output sbp_pkg::result_t   result
);
    import sbp_pkg::*;

    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(BUCKETS);

    // tables; an entry whose valid bit is clear reads as zero
    logic [63:0]        spl_mem  [NSPLIT];
    logic [31:0]        base_mem [BUCKETS];
    logic [31:0]        fill_mem [BUCKETS];
    logic [NSPLIT-1:0]  spl_vld_reg;
    logic [BUCKETS-1:0] base_vld_reg;
    logic [BUCKETS-1:0] fill_vld_reg;

    // captured request
    logic [2:0]  op_reg;
    logic [5:0]  slot_reg;
    logic [63:0] key_reg;
    logic [63:0] tag_reg;

    // search
    logic [LOC_W-1:0] loc_reg, loc_next;
    logic [LOC_W-1:0] step_reg, step_next;
    logic [LOC_W-1:0] probe_idx;
    logic             probe_oob;
    logic             probe_oob_reg;
    logic [63:0]      spl_q_reg;
    logic             spl_hit_reg;
    logic             key_below;
    logic [LOC_W-1:0] final_loc;
    logic [BKT_W-1:0] bkt_final;
    logic [BKT_W-1:0] bkt_reg;

    // bucket reads
    logic [BKT_W-1:0] bkt_raddr;
    logic [31:0]      base_q_reg, fill_q_reg;
    logic             base_hit_reg, fill_hit_reg;
    logic [31:0]      base_eff, fill_eff;

    // writes
    logic [BKT_W-1:0] slot_idx;
    logic             spl_we;
    logic             base_we;
    logic [BKT_W-1:0] base_waddr;
    logic [31:0]      base_wdata;

    // prefix sweep
    logic [CNT_W-1:0] cnt_reg;
    logic             pend_reg;
    logic [BKT_W-1:0] pend_idx_reg;
    logic [31:0]      run_reg;
    logic [31:0]      run_sum;
    logic             sweep_issue;

    // result
    logic    emit;
    result_t res_next;
    result_t result_reg;
    logic    done_reg;

    assign slot_idx  = BKT_W'(request.slot);
    assign base_eff  = base_hit_reg ? base_q_reg : '0;
    assign fill_eff  = fill_hit_reg ? fill_q_reg : '0;
    assign key_below = probe_oob_reg || (spl_hit_reg && (key_reg < spl_q_reg));

    // search step: halve the step each round, final probe decides the last unit
    always_comb
    begin
        loc_next  = loc_reg;
        step_next = step_reg;
        if (cmd.load)
        begin
            loc_next  = LOC_W'(SPAN / 2);
            step_next = LOC_W'(SPAN / 4);
        end
        else if (cmd.probe && (step_reg != '0))
        begin
            loc_next  = key_below ? (loc_reg - step_reg) : (loc_reg + step_reg);
            step_next = step_reg >> 1;
        end
    end

    assign probe_idx = loc_next - LOC_W'(1);
    assign probe_oob = (probe_idx >= LOC_W'(NSPLIT));
    assign final_loc = key_below ? (loc_reg - LOC_W'(1)) : loc_reg;
    assign bkt_final = (final_loc > LOC_W'(NSPLIT)) ? BKT_W'(NSPLIT)
                                                   : final_loc[BKT_W-1:0];

    assign stat.search_last = (step_reg == '0);
    assign stat.sweep_last  = (cnt_reg == CNT_END);

    always_comb
    begin
        bkt_raddr = cnt_reg[BKT_W-1:0];
        if (cmd.load)
        begin
            bkt_raddr = slot_idx;
        end
        else if (cmd.probe)
        begin
            bkt_raddr = bkt_final;
        end
    end

    assign sweep_issue = cmd.sweep && (cnt_reg < CNT_END);
    assign run_sum     = run_reg + fill_eff;

    assign spl_we = cmd.load && (request.operation == OP_SET_SPLITTER)
                    && (LOC_W'(request.slot) < LOC_W'(NSPLIT));

    always_comb
    begin
        base_we    = 1'b0;
        base_waddr = pend_idx_reg;
        base_wdata = run_reg;
        if (cmd.load && (request.operation == OP_SET_BASE)
            && (LOC_W'(request.slot) < LOC_W'(BUCKETS)))
        begin
            base_we    = 1'b1;
            base_waddr = slot_idx;
            base_wdata = request.offset_value;
        end
        else if (cmd.sweep && pend_reg)
        begin
            base_we = 1'b1;
        end
    end

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (spl_we)
        begin
            spl_mem[slot_idx] <= request.sort_key;
        end
        if (!probe_oob)
        begin
            spl_q_reg <= spl_mem[probe_idx[BKT_W-1:0]];
        end
        spl_hit_reg   <= probe_oob ? 1'b0 : spl_vld_reg[probe_idx[BKT_W-1:0]];
        probe_oob_reg <= probe_oob;
    end

    always_ff @(posedge clk)
    begin
        if (base_we)
        begin
            base_mem[base_waddr] <= base_wdata;
        end
        base_q_reg   <= base_mem[bkt_raddr];
        base_hit_reg <= base_vld_reg[bkt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            fill_mem[bkt_reg] <= fill_eff + 32'd1;
        end
        fill_q_reg   <= fill_mem[bkt_raddr];
        fill_hit_reg <= fill_vld_reg[bkt_raddr];
    end

    // valid bits; prefix clears a fill by dropping its valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spl_vld_reg  <= '0;
            base_vld_reg <= '0;
            fill_vld_reg <= '0;
        end
        else
        begin
            if (spl_we)
            begin
                spl_vld_reg[slot_idx] <= 1'b1;
            end
            if (base_we)
            begin
                base_vld_reg[base_waddr] <= 1'b1;
            end
            if (cmd.update)
            begin
                fill_vld_reg[bkt_reg] <= 1'b1;
            end
            else if (cmd.sweep && pend_reg)
            begin
                fill_vld_reg[pend_idx_reg] <= 1'b0;
            end
        end
    end

    // request capture and search registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= request.operation;
            slot_reg <= request.slot;
            key_reg  <= request.sort_key;
            tag_reg  <= request.record_tag;
        end
        loc_reg  <= loc_next;
        step_reg <= step_next;
        if (cmd.probe)
        begin
            bkt_reg <= bkt_final;
        end
        if (cmd.load)
        begin
            run_reg <= request.offset_value;
        end
        else if (cmd.sweep && pend_reg)
        begin
            run_reg <= run_sum;
        end
        pend_idx_reg <= cnt_reg[BKT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.sweep)
        begin
            pend_reg <= sweep_issue;
            if (sweep_issue)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // result beat
    always_comb
    begin
        res_next        = '0;
        res_next.bucket = slot_reg;
        if (cmd.update)
        begin
            res_next.bucket   = 6'(bkt_reg);
            res_next.position = base_eff + fill_eff;
            res_next.out_key  = key_reg;
            res_next.out_tag  = tag_reg;
        end
        else if (cmd.finish)
        begin
            if ((op_reg == OP_READ) && (LOC_W'(slot_reg) < LOC_W'(BUCKETS)))
            begin
                res_next.position   = base_eff;
                res_next.read_value = fill_eff;
            end
        end
        else if (cmd.sweep)
        begin
            res_next.read_value = run_sum;
        end
    end

    assign emit = cmd.update || cmd.finish || (cmd.sweep && stat.sweep_last);

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= emit;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.probe, cmd.update, cmd.sweep, cmd.finish}))
        else $error("more than one datapath command at once");

    a_step_halves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe && (step_reg != '0) |=> step_reg == ($past(step_reg) >> 1))
        else $error("search step did not halve");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(cmd.update) || $past(cmd.finish) || $past(cmd.sweep)))
        else $error("result beat without a finishing command");

    a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep && pend_reg |-> (CNT_W'(pend_idx_reg) + CNT_W'(1)) == cnt_reg)
        else $error("prefix sweep out of bucket order");

endmodule

/* hdl/splitter_bucket_partitioner_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splitter_bucket_partitioner_top: bucket partition step of a sample sort
// Classifies keys against a sorted splitter table and hands out destination
// positions per bucket; also loads splitters and bases, reads buckets back and
// turns fill counts into exclusive base offsets.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; every request
// returns exactly one result beat, shown for one cycle with done high, and the
// receiver must take it then. Set splitter, set base, read bucket and unused
// codes pass through the finish state, and done rises from the result register
// after it. Classify is a binary search with one registered splitter-table
// read per probe (6 probes for 64 buckets), then the fill read-modify-write.
// Prefix walks the fill table one bucket per cycle. Busy stays high until the
// operation ends, so no new beat is taken before then. All tables read as zero
// after reset without any clearing pass.
module splitter_bucket_partitioner_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sbp_pkg::request_t request,
    output logic              busy,
    output logic              done,
    output sbp_pkg::result_t  result
);
    import sbp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .stat      (stat),
        .busy      (busy),
        .cmd       (cmd)
    );

    sbp_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule
